// ===== rtl/rcs_pkg.sv =====
// -----------------------------------------------------------------------------
// rcs_pkg
// Shared types and constants of the sixteen-bit core step unit: transaction
// payloads, instruction kinds and the execute result bundle.
// -----------------------------------------------------------------------------
package rcs_pkg;

   // transaction opcodes
   localparam logic [1:0] OP_LOAD_MEM = 2'd0;
   localparam logic [1:0] OP_STEP     = 2'd1;
   localparam logic [1:0] OP_READ_MEM = 2'd2;
   localparam logic [1:0] OP_READ_REG = 2'd3;

   // instruction kinds, bits 15..13
   typedef enum logic [2:0] {
      K_ADD  = 3'd0,
      K_ADDI = 3'd1,
      K_NAND = 3'd2,
      K_LUI  = 3'd3,
      K_SW   = 3'd4,
      K_LW   = 3'd5,
      K_BEQ  = 3'd6,
      K_JALR = 3'd7
   } kind_type;

   localparam logic [15:0] PC_STEP    = 16'h0002;
   localparam logic [15:0] EVEN_MASK  = 16'hFFFE;
   localparam int unsigned LUI_SHIFT  = 6;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [14:0] address;
      logic [15:0] data;
   } req_type;

   typedef struct packed {
      logic [15:0] pc_after;
      logic [15:0] instruction_word;
      logic        reg_written;
      logic [2:0]  reg_index;
      logic [15:0] reg_value;
      logic        mem_written;
      logic [15:0] mem_byte_address;
      logic [15:0] mem_value;
      logic [15:0] read_data;
   } rsp_type;

   // what the execute stage decided for one instruction
   typedef struct packed {
      logic        reg_we;
      logic [15:0] reg_value;
      logic        mem_we;
      logic [15:0] mem_addr;
      logic [15:0] mem_value;
      logic        load;
      logic [15:0] next_pc;
   } exec_type;

   function automatic logic [15:0] sext7(input logic [6:0] v);
      return {{9{v[6]}}, v};
   endfunction

endpackage

// ===== rtl/rcs_word_ram.sv =====
// -----------------------------------------------------------------------------
// rcs_word_ram
// Single-port word memory, one access per cycle, registered read data that
// holds until the next read.
// -----------------------------------------------------------------------------
module rcs_word_ram #(
   parameter int unsigned DEPTH = 32768,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          we,
   input  logic          re,
   input  logic [AW-1:0] addr,
   input  logic [15:0]   wr_data,
   output logic [15:0]   rd_data
);

   logic [15:0] mem [DEPTH];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wr_data;
      end else if (re) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rcs_reg_ram.sv =====
// -----------------------------------------------------------------------------
// rcs_reg_ram
// Eight-entry register file: one write port, two registered read ports.
// -----------------------------------------------------------------------------
module rcs_reg_ram (
   input  logic        clock,
   input  logic        we,
   input  logic [2:0]  wr_addr,
   input  logic [15:0] wr_data,
   input  logic        re_a,
   input  logic [2:0]  addr_a,
   output logic [15:0] rd_a,
   input  logic        re_b,
   input  logic [2:0]  addr_b,
   output logic [15:0] rd_b
);

   logic [15:0] regs [8];
   logic [15:0] rd_a_ff;
   logic [15:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         regs[wr_addr] <= wr_data;
      end
      if (re_a) begin
         rd_a_ff <= regs[addr_a];
      end
      if (re_b) begin
         rd_b_ff <= regs[addr_b];
      end
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

// ===== rtl/rcs_alu.sv =====
// -----------------------------------------------------------------------------
// rcs_alu
// Execute stage: computes register result, store address, load request and
// next program counter for one decoded instruction.
// -----------------------------------------------------------------------------
module rcs_alu
   import rcs_pkg::*;
#(
   parameter logic [15:0] RAM_BASE = 16'h0400
) (
   input  logic [15:0] insn,
   input  logic [15:0] pc,
   input  logic [15:0] vb,
   input  logic [15:0] vx,   // rc for ADD and NAND, ra otherwise
   output exec_type    ex
);

   kind_type    kind;
   logic [2:0]  ra;
   logic [15:0] imm;
   logic [15:0] imm2;
   logic [15:0] pc_next;
   logic [16:0] pc_wide;
   logic [15:0] data_addr;
   logic        wr;

   assign kind      = kind_type'(insn[15:13]);
   assign ra        = insn[12:10];
   assign imm       = sext7(insn[6:0]);
   assign imm2      = {imm[14:0], 1'b0};
   assign pc_next   = pc + PC_STEP;
   assign pc_wide   = {1'b0, pc} + 17'(PC_STEP);
   assign data_addr = (vb + imm2 + RAM_BASE) & EVEN_MASK;

   always_comb begin
      ex           = '0;
      ex.next_pc   = pc_next;
      wr           = 1'b0;
      case (kind)
         K_ADD: begin
            ex.reg_value = vb + vx;
            wr           = 1'b1;
         end
         K_ADDI: begin
            ex.reg_value = vb + imm;
            wr           = 1'b1;
         end
         K_NAND: begin
            ex.reg_value = ~(vb & vx);
            wr           = 1'b1;
         end
         K_LUI: begin
            ex.reg_value = 16'(insn[9:0]) << LUI_SHIFT;
            wr           = 1'b1;
         end
         K_SW: begin
            ex.mem_we    = 1'b1;
            ex.mem_addr  = data_addr;
            ex.mem_value = vx;
         end
         K_LW: begin
            ex.load     = 1'b1;
            ex.mem_addr = data_addr;
            wr          = 1'b1;
         end
         K_BEQ: begin
            if (vx == vb) begin
               ex.next_pc = pc + {imm[14:0] + 15'd1, 1'b0};
            end
         end
         K_JALR: begin
            ex.next_pc   = {vb[14:0], 1'b0};
            ex.reg_value = pc_wide[16:1];
            wr           = 1'b1;
         end
         default: begin
            wr = 1'b0;
         end
      endcase
      // r0 is never written
      ex.reg_we = wr && (ra != 3'd0);
   end

endmodule

// ===== rtl/risc16_core_step_unit.sv =====
// -----------------------------------------------------------------------------
// risc16_core_step_unit
// Sixteen-bit core with eight registers and a word memory; each transaction
// loads or reads a memory word, reads a register, or steps one instruction.
// -----------------------------------------------------------------------------
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_ready   req_item (req_type)
//   rsp_      out        rsp_valid/rsp_ready   rsp_item (rsp_type)
//
// Memory loads and reads are issued in the accepting cycle and finish in the
// simple state. A step fetches in the accepting cycle, then reads registers
// (decode) and executes; LW adds a data read, and the store of SW holds the
// single memory port in the execute state, so no new transaction is taken.
// After reset a clearing pass writes zero to all MEM_WORDS memory words, one
// per cycle, with req_ready low; the same pass also writes zero to the
// register file, indexed by the low three bits of the word counter.
// A full result register that is not taken stalls the transaction in its
// last cycle; a new transaction is accepted in the cycle the previous one
// completes, unless that one is a store holding the memory port.
// -----------------------------------------------------------------------------
module risc16_core_step_unit
   import rcs_pkg::*;
#(
   parameter int unsigned MEM_WORDS = 32768,
   parameter int unsigned RAM_BASE  = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item
);

   localparam int unsigned AW = $clog2(MEM_WORDS);

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_SIMPLE = 6'b000100,
      ST_DECODE = 6'b001000,
      ST_EXEC   = 6'b010000,
      ST_LOAD   = 6'b100000
   } st_type;

   // Reduce a word index modulo MEM_WORDS with five compare-subtract steps
   // (indices are below 32 * MEM_WORDS).
   function automatic logic [AW-1:0] wrap_idx(input logic [14:0] idx);
      logic [20:0] v;
      v = {6'd0, idx};
      for (int k = 4; k >= 0; k--) begin
         if (v >= (21'(MEM_WORDS) << k)) begin
            v = v - (21'(MEM_WORDS) << k);
         end
      end
      return v[AW-1:0];
   endfunction

   st_type      state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [1:0]  op_ff, op_in;
   logic [15:0] insn_ff, insn_in;
   logic [15:0] pc_ff, pc_in;
   logic        fwd_ff, fwd_in;
   logic [15:0] fwd_data_ff, fwd_data_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_item_ff, rsp_item_in;

   // memory port
   logic          ram_we, ram_re;
   logic [AW-1:0] ram_addr;
   logic [15:0]   ram_wdata, ram_rdata;

   // register file ports
   logic        rf_we, rf_re_a, rf_re_b;
   logic [2:0]  rf_waddr, rf_addr_a, rf_addr_b;
   logic [15:0] rf_wdata, rf_rd_a, rf_rd_b;

   exec_type    ex;
   logic        st_clear, st_idle, st_simple, st_decode, st_exec, st_load;
   logic        out_free, fin, req_fire;
   kind_type    dec_kind;
   st_type      st_after;
   logic [2:0]  insn_ra;

   assign st_clear  = (state_ff == ST_CLEAR);
   assign st_idle   = (state_ff == ST_IDLE);
   assign st_simple = (state_ff == ST_SIMPLE);
   assign st_decode = (state_ff == ST_DECODE);
   assign st_exec   = (state_ff == ST_EXEC);
   assign st_load   = (state_ff == ST_LOAD);
   assign insn_ra   = insn_ff[12:10];

   rcs_word_ram #(
      .DEPTH(MEM_WORDS)
   ) u_word_ram (
      .clock  (clock),
      .we     (ram_we),
      .re     (ram_re),
      .addr   (ram_addr),
      .wr_data(ram_wdata),
      .rd_data(ram_rdata)
   );

   rcs_reg_ram u_reg_ram (
      .clock  (clock),
      .we     (rf_we),
      .wr_addr(rf_waddr),
      .wr_data(rf_wdata),
      .re_a   (rf_re_a),
      .addr_a (rf_addr_a),
      .rd_a   (rf_rd_a),
      .re_b   (rf_re_b),
      .addr_b (rf_addr_b),
      .rd_b   (rf_rd_b)
   );

   // Execute from the held instruction and the register operands read in
   // the decode cycle; port b carries rc for ADD/NAND and ra otherwise.
   rcs_alu #(
      .RAM_BASE(16'(RAM_BASE))
   ) u_alu (
      .insn(insn_ff),
      .pc  (pc_ff),
      .vb  (rf_rd_a),
      .vx  (rf_rd_b),
      .ex  (ex)
   );

   // Complete a transaction only when the result register can take it.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign fin      = out_free && (st_simple || (st_exec && !ex.load) || st_load);
   // Accept when idle, or on completion unless a store holds the memory port.
   assign req_ready = st_idle || (fin && !(st_exec && ex.mem_we));
   assign req_fire  = req_valid && req_ready;

   // Advance the program counter when leaving execute (LW included).
   assign pc_in = (st_exec && (fin || ex.load)) ? ex.next_pc : pc_ff;

   // ---------------------------------------------------------------- memory
   always_comb begin
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_addr  = '0;
      ram_wdata = '0;
      if (st_clear) begin
         ram_we   = 1'b1;
         ram_addr = clr_ff;
      end else if (st_exec && ex.mem_we && out_free) begin
         ram_we    = 1'b1;
         ram_addr  = wrap_idx(ex.mem_addr[15:1]);
         ram_wdata = ex.mem_value;
      end else if (st_exec && ex.load) begin
         ram_re   = 1'b1;
         ram_addr = wrap_idx(ex.mem_addr[15:1]);
      end else if (req_fire) begin
         case (req_item.opcode)
            OP_LOAD_MEM: begin
               ram_we    = 1'b1;
               ram_addr  = wrap_idx(req_item.address);
               ram_wdata = req_item.data;
            end
            OP_READ_MEM: begin
               ram_re   = 1'b1;
               ram_addr = wrap_idx(req_item.address);
            end
            OP_STEP: begin
               // fetch at the counter this edge leaves behind
               ram_re   = 1'b1;
               ram_addr = wrap_idx(pc_in[15:1]);
            end
            default: begin
               ram_re = 1'b0;
            end
         endcase
      end
   end

   // --------------------------------------------------------- register file
   assign dec_kind = kind_type'(ram_rdata[15:13]);

   always_comb begin
      rf_we    = 1'b0;
      rf_waddr = insn_ra;
      rf_wdata = ex.reg_value;
      if (st_clear) begin
         rf_we    = 1'b1;
         rf_waddr = clr_ff[2:0];
         rf_wdata = '0;
      end else if (st_exec && fin && ex.reg_we) begin
         rf_we = 1'b1;
      end else if (st_load && fin && (insn_ra != 3'd0)) begin
         rf_we    = 1'b1;
         rf_wdata = ram_rdata;
      end
   end

   assign rf_re_a   = st_decode || (req_fire && (req_item.opcode == OP_READ_REG));
   assign rf_addr_a = st_decode ? ram_rdata[9:7] : req_item.address[2:0];
   assign rf_re_b   = st_decode;
   assign rf_addr_b = (dec_kind == K_ADD || dec_kind == K_NAND) ? ram_rdata[2:0]
                                                               : ram_rdata[12:10];

   // A register read accepted in the same cycle as a write to that register
   // takes the written value.
   assign fwd_in      = rf_we && (rf_waddr == req_item.address[2:0]);
   assign fwd_data_in = rf_wdata;

   // ------------------------------------------------------------ sequencing
   assign st_after = !req_fire                   ? ST_IDLE   :
                     (req_item.opcode == OP_STEP) ? ST_DECODE : ST_SIMPLE;

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(MEM_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_DECODE: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (ex.load) begin
               state_in = ST_LOAD;
            end else if (fin) begin
               state_in = st_after;
            end
         end
         ST_IDLE, ST_SIMPLE, ST_LOAD: begin
            if (st_idle || fin) begin
               state_in = st_after;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign op_in   = req_fire ? req_item.opcode : op_ff;
   assign insn_in = st_decode ? ram_rdata : insn_ff;

   // ---------------------------------------------------------------- result
   always_comb begin
      rsp_item_in          = '0;
      rsp_item_in.pc_after = pc_ff;
      if (st_simple) begin
         case (op_ff)
            OP_READ_MEM: rsp_item_in.read_data = ram_rdata;
            OP_READ_REG: rsp_item_in.read_data = fwd_ff ? fwd_data_ff : rf_rd_a;
            default:     rsp_item_in.read_data = '0;
         endcase
      end else if (st_load) begin
         rsp_item_in.instruction_word = insn_ff;
         if (insn_ra != 3'd0) begin
            rsp_item_in.reg_written = 1'b1;
            rsp_item_in.reg_index   = insn_ra;
            rsp_item_in.reg_value   = ram_rdata;
         end
      end else begin
         rsp_item_in.pc_after         = ex.next_pc;
         rsp_item_in.instruction_word = insn_ff;
         rsp_item_in.mem_written      = ex.mem_we;
         rsp_item_in.mem_byte_address = ex.mem_addr;
         rsp_item_in.mem_value        = ex.mem_value;
         if (ex.reg_we) begin
            rsp_item_in.reg_written = 1'b1;
            rsp_item_in.reg_index   = insn_ra;
            rsp_item_in.reg_value   = ex.reg_value;
         end
      end
   end

   assign rsp_valid_in = fin || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      insn_ff <= insn_in;
      if (req_fire) begin
         fwd_ff      <= fwd_in;
         fwd_data_ff <= fwd_data_in;
      end
      if (fin) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // ------------------------------------------------------------ assertions
   a_pc_even: assert property (@(posedge clock) disable iff (reset)
      !pc_ff[0])
      else $error("program counter is odd");

   a_port_single: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("memory read and write in one cycle");

   a_no_r0_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.reg_written) |-> (rsp_item_ff.reg_index != 3'd0))
      else $error("result reports a write to r0");

   a_step_decodes: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_item.opcode == OP_STEP)) |=> (state_ff == ST_DECODE))
      else $error("accepted step did not enter decode");

   a_accept_ends_prev: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !st_idle) |-> fin)
      else $error("transaction accepted while another is in flight");

endmodule

// ===== sim/risc16_core_step_unit_test.sv =====
// -----------------------------------------------------------------------------
// risc16_core_step_unit_test
// Self-checking bench for the sixteen-bit core step unit. A scoreboard keeps
// its own copy of the program counter, register file and word memory. It works
// out each response from the accepted request and compares the responses
// field by field. The stimulus runs a short directed program over every
// instruction kind and the corner cases, then random program bursts, memory
// and register traffic, and noise. Both channels idle at random.
// -----------------------------------------------------------------------------
module risc16_core_step_unit_test
   import rcs_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MEM_WORDS      = 32768;
   localparam int unsigned RAM_BASE       = 1024;
   localparam int          RANDOM_ITEMS   = 1700;
   localparam int          CALM_TAIL      = 200;     // last items run with no idling
   localparam int          WATCHDOG_LIMIT = 100000;  // covers the memory clearing pass
   localparam int          DRAIN_CYCLES   = 16;

   // ---------------------------------------------------------------------------
   // Scoreboard: the core model, the queue of pending responses and the checks
   // ---------------------------------------------------------------------------
   class core_scoreboard;
      logic [15:0] pc;
      logic [15:0] regs [0:7];
      logic [15:0] mem_words [0:MEM_WORDS-1];
      logic [14:0] last_store_slot;
      rsp_type     expected_rsp [$];
      int          error_count;
      int          n_items, n_steps, n_reg_writes, n_stores, n_taken, n_jumps;

      function new();
         pc = '0;
         foreach (regs[i]) regs[i] = '0;
         foreach (mem_words[i]) mem_words[i] = '0;
         last_store_slot = '0;
         error_count = 0;
         n_items = 0;
         n_steps = 0;
         n_reg_writes = 0;
         n_stores = 0;
         n_taken = 0;
         n_jumps = 0;
      endfunction

      // Apply one request to the model state and return the response it causes.
      function rsp_type execute_item(req_type r);
         rsp_type     o;
         logic [15:0] insn, imm, va, vb, vc, res, nxt, ea;
         logic [16:0] link;
         logic [2:0]  ra, rb, rc;
         kind_type    k;
         bit          wr;
         o = '0;
         case (r.opcode)
            OP_LOAD_MEM: mem_words[r.address] = r.data;
            OP_READ_MEM: o.read_data = mem_words[r.address];
            OP_READ_REG: o.read_data = regs[r.address[2:0]];
            default: begin
               insn = mem_words[pc[15:1]];
               k    = kind_type'(insn[15:13]);
               ra   = insn[12:10];
               rb   = insn[9:7];
               rc   = insn[2:0];
               imm  = {{9{insn[6]}}, insn[6:0]};
               va   = regs[ra];
               vb   = regs[rb];
               vc   = regs[rc];
               nxt  = pc + PC_STEP;
               res  = '0;
               wr   = 1'b0;
               ea   = ((vb + (imm << 1) + 16'(RAM_BASE)) & EVEN_MASK);
               case (k)
                  K_ADD: begin
                     res = vb + vc;
                     wr  = 1'b1;
                  end
                  K_ADDI: begin
                     res = vb + imm;
                     wr  = 1'b1;
                  end
                  K_NAND: begin
                     res = ~(vb & vc);
                     wr  = 1'b1;
                  end
                  K_LUI: begin
                     res = {insn[9:0], 6'b0};
                     wr  = 1'b1;
                  end
                  K_SW: begin
                     mem_words[ea[15:1]] = va;
                     last_store_slot = ea[15:1];
                     o.mem_written = 1'b1;
                     o.mem_byte_address = ea;
                     o.mem_value = va;
                     n_stores++;
                  end
                  K_LW: begin
                     res = mem_words[ea[15:1]];
                     wr  = 1'b1;
                  end
                  K_BEQ: begin
                     if (va == vb) begin
                        nxt = pc + ((imm + 16'd1) << 1);
                        n_taken++;
                     end
                  end
                  default: begin
                     // link is formed in seventeen bits so the top of memory gives 0x8000
                     link = {1'b0, pc} + 17'd2;
                     res  = link[16:1];
                     nxt  = {vb[14:0], 1'b0};
                     wr   = 1'b1;
                     n_jumps++;
                  end
               endcase
               if (wr && ra != 3'd0) begin
                  regs[ra] = res;
                  o.reg_written = 1'b1;
                  o.reg_index = ra;
                  o.reg_value = res;
                  n_reg_writes++;
               end
               o.instruction_word = insn;
               pc = nxt;
               n_steps++;
            end
         endcase
         o.pc_after = pc;
         return o;
      endfunction

      function void note_request(req_type r);
         expected_rsp.push_back(execute_item(r));
         n_items++;
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH @%0t: %s", $time, msg);
         error_count++;
      endtask

      task compare_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (expected_rsp.size() == 0) begin
            report_mismatch("response with no request pending");
         end else begin
            want = expected_rsp.pop_front();
            compare_field("pc_after", got.pc_after, want.pc_after);
            compare_field("instruction_word", got.instruction_word, want.instruction_word);
            compare_field("reg_written", 16'(got.reg_written), 16'(want.reg_written));
            compare_field("reg_index", 16'(got.reg_index), 16'(want.reg_index));
            compare_field("reg_value", got.reg_value, want.reg_value);
            compare_field("mem_written", 16'(got.mem_written), 16'(want.mem_written));
            compare_field("mem_byte_address", got.mem_byte_address, want.mem_byte_address);
            compare_field("mem_value", got.mem_value, want.mem_value);
            compare_field("read_data", got.read_data, want.read_data);
         end
      endtask
   endclass

   // ---------------------------------------------------------------------------
   // Clock, reset, DUT
   // ---------------------------------------------------------------------------
   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_item;

   core_scoreboard sb = new();
   bit  idle_on = 1'b1;      // random gaps on both channels while set
   int  items_sent = 0;
   int  quiet_cycles = 0;
   int  stall_left = 0;
   bit  have_store = 1'b0;   // a store was generated; loads may reuse its address
   logic [2:0] last_sw_base;
   logic [6:0] last_sw_imm;

   always #2 clock = ~clock;

   risc16_core_step_unit #(
      .MEM_WORDS(MEM_WORDS),
      .RAM_BASE (RAM_BASE)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item (rsp_item)
   );

   // ---------------------------------------------------------------------------
   // Monitor: sample both handshakes at the rising edge, before the DUT updates
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_item);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_item);
      end
   end

   // Watchdog: count cycles with no transaction on either channel. The limit
   // leaves room for the clearing pass that holds req_ready low after reset.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d responses pending",
                  quiet_cycles, sb.expected_rsp.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Response side: hold rsp_ready low in random bursts.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else begin
         rsp_ready = 1'b1;
         if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
      end
   end

   // ---------------------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------------------
   // Present one transaction at the falling edge and hold it until accepted.
   // Valid stays high on return, so back-to-back items never drop it in between.
   task automatic send_item(input logic [1:0] op, input logic [14:0] addr,
                            input logic [15:0] data);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_item.opcode  = op;
      req_item.address = addr;
      req_item.data    = data;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      @(negedge clock);
   endtask

   function automatic logic [15:0] encode(kind_type k, logic [2:0] a, logic [2:0] b,
                                          logic [6:0] low);
      return {k, a, b, low};
   endfunction

   // Random instruction; bias branches toward equal operands and loads toward
   // the address of the last generated store so loaded data is often nonzero.
   function automatic logic [15:0] random_instruction();
      kind_type   k;
      logic [2:0] a, b;
      logic [6:0] low;
      k   = kind_type'($urandom_range(0, 7));
      a   = 3'($urandom);
      b   = 3'($urandom);
      low = 7'($urandom);
      if (k == K_BEQ && $urandom_range(0, 1) == 1) b = a;
      if (k == K_LW && have_store && $urandom_range(0, 1) == 1) begin
         b   = last_sw_base;
         low = last_sw_imm;
      end
      if (k == K_SW) begin
         last_sw_base = b;
         last_sw_imm  = low;
         have_store   = 1'b1;
      end
      return encode(k, a, b, low);
   endfunction

   // Load a short program at the current PC, then step through it. Branches
   // and jumps may leave the program early; the steps then run whatever is there.
   task automatic run_program_burst();
      int          n;
      logic [14:0] slot;
      n    = $urandom_range(1, 8);
      slot = sb.pc[15:1];
      repeat (n) begin
         send_item(OP_LOAD_MEM, slot, random_instruction());
         slot = slot + 15'd1;
      end
      repeat (n) send_item(OP_STEP, 15'($urandom), 16'($urandom));
      if ($urandom_range(0, 2) == 0) send_item(OP_READ_REG, 15'($urandom), 16'($urandom));
   endtask

   // Directed program: every instruction kind, a write to r0 by a load, a taken
   // and an untaken branch, address wrap on the store, and a jump to the top
   // of memory whose link value needs the seventeenth bit.
   task automatic run_directed();
      send_item(OP_LOAD_MEM, 15'd0, encode(K_LUI, 3'd1, 3'd3, 7'h7F));   // r1 = 0x7FC0
      send_item(OP_LOAD_MEM, 15'd1, encode(K_ADDI, 3'd1, 3'd1, 7'd63));  // r1 = 0x7FFF
      send_item(OP_LOAD_MEM, 15'd2, encode(K_ADD, 3'd4, 3'd1, 7'd1));    // r4 = 0xFFFE
      send_item(OP_LOAD_MEM, 15'd3, encode(K_NAND, 3'd5, 3'd1, 7'd4));   // r5 = 0x8001
      send_item(OP_LOAD_MEM, 15'd4, encode(K_SW, 3'd5, 3'd4, 7'h40));    // wraps past 0xFFFF
      send_item(OP_LOAD_MEM, 15'd5, encode(K_LW, 3'd6, 3'd4, 7'h40));
      send_item(OP_LOAD_MEM, 15'd6, encode(K_LW, 3'd0, 3'd4, 7'h40));    // r0 stays zero
      send_item(OP_LOAD_MEM, 15'd7, encode(K_BEQ, 3'd5, 3'd6, 7'd1));    // taken, skip one
      send_item(OP_LOAD_MEM, 15'd9, encode(K_BEQ, 3'd1, 3'd4, 7'h7F));   // not taken
      send_item(OP_LOAD_MEM, 15'd10, encode(K_JALR, 3'd2, 3'd1, 7'd0));  // PC = 0xFFFE
      send_item(OP_LOAD_MEM, 15'h7FFF, encode(K_JALR, 3'd3, 3'd0, 7'd0));
      repeat (11) send_item(OP_STEP, 15'h7FFF, 16'hFFFF);
      send_item(OP_READ_REG, 15'h7FFF, 16'h0000);                        // high bits ignored
      send_item(OP_READ_MEM, 15'h01BF, 16'h0000);                        // wrapped store target
      send_item(OP_READ_MEM, 15'h7FFF, 16'hFFFF);
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      int          pick;
      logic [14:0] slot;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_directed();

      // Mostly well-formed program bursts; the rest is memory and register
      // traffic plus fully random noise. Idling is set at random per sequence,
      // and the tail runs flat out.
      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent >= RANDOM_ITEMS - CALM_TAIL) idle_on = 1'b0;
         else idle_on = ($urandom_range(0, 4) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            run_program_burst();
         end else if (pick < 65) begin
            slot = ($urandom_range(0, 1) == 1) ? sb.last_store_slot : 15'($urandom);
            send_item(OP_READ_MEM, slot, 16'($urandom));
         end else if (pick < 75) begin
            send_item(OP_READ_REG, 15'($urandom), 16'($urandom));
         end else if (pick < 85) begin
            slot = 15'($urandom);
            send_item(OP_LOAD_MEM, slot, 16'($urandom));
            send_item(OP_READ_MEM, slot, 16'($urandom));
         end else begin
            send_item(2'($urandom), 15'($urandom), 16'($urandom));
         end
      end
      req_valid = 1'b0;

      // Drain: wait for every pending response, then let the pipeline settle.
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d transactions, %0d of them instruction steps.",
               sb.n_items, sb.n_steps);
      $display("Steps wrote %0d registers and %0d memory words, took %0d branches, %0d jumps.",
               sb.n_reg_writes, sb.n_stores, sb.n_taken, sb.n_jumps);
      if (sb.error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
